// ===== rtl/core/tdl_pkg.sv =====
// Package for the timeout delta list: sizes, command codes, cell structs.
// No dependencies.
package tdl_pkg;
    localparam int CAPACITY = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELEASE
    } state_t;

    // due: ticks left until release, counted from now
    typedef struct packed {
        logic [15:0] due;
        logic [7:0]  thread;
        logic [7:0]  sem;
    } entry_t;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic        ins;
        logic        rem;
        logic        dec;
        logic        pop;
        logic [7:0]  thread;
        logic [7:0]  sem;
        logic [15:0] timeout;
    } cell_op_t;

    // what a cell tells its right-hand neighbor
    typedef struct packed {
        logic        past_ins;   // insert point lies at or before this cell
        logic        past_rem;   // removed entry lies at or before this cell
    } chain_t;
endpackage

// ===== rtl/core/timeout_delta_list_unit.sv =====
// Top level of the timeout delta list unit: stream ports and release sequencer.
// Depends on tdl_pkg and tdl_chain.
//
// Each cell keeps the total wait of its entry, so an insert or remove settles in
// a single update of the cell chain without summing waits along the row. A tick
// first decrements the waits; when the list is not empty it then releases the
// due entries one by one, each release popping the head of the chain once the
// previous release item is taken, and then closes; at most MAX_RESULTS entries
// go per tick.
module timeout_delta_list_unit import tdl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // thread_id[7:0], sem_id[15:8], timeout[31:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // released_thread[7:0], released_sem[15:8]
    output logic        m_tlast    // last_of_tick
);
    state_t state_reg, state_next;
    logic [RES_W-1:0] n_reg, n_next;
    logic        ov_reg, ov_next;
    logic [15:0] od_reg, od_next;
    logic        ol_reg, ol_next;
    cell_op_t    op;
    entry_t      head, second;
    logic        head_occ, second_occ, full, acc, can_pop, more_rel;

    tdl_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .head       (head),
        .head_occ   (head_occ),
        .second     (second),
        .second_occ (second_occ),
        .full       (full)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign acc = s_tvalid && s_tready;
    assign can_pop = head_occ && head.due == 16'd0 && n_reg < RES_W'(MAX_RESULTS);
    // another release follows this pop in the same tick
    assign more_rel = second_occ && second.due == 16'd0 &&
                      (n_reg + 1'b1) < RES_W'(MAX_RESULTS);

    always_comb
    begin
        op = '0;
        op.thread  = s_tdata[7:0];
        op.sem     = s_tdata[15:8];
        op.timeout = s_tdata[31:16];
        state_next = state_reg;
        n_next  = n_reg;
        ov_next = ov_reg && !m_tready;
        od_next = od_reg;
        ol_next = ol_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd_t'(s_tuser))
                        CMD_INSERT: op.ins = !full;
                        CMD_REMOVE: op.rem = 1'b1;
                        CMD_TICK:
                        begin
                            op.dec = head.due != 16'd0;
                            n_next = '0;
                            if (head_occ)
                                state_next = ST_RELEASE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RELEASE:
            begin
                if (!ov_reg || m_tready)
                begin
                    if (can_pop)
                    begin
                        op.pop  = 1'b1;
                        ov_next = 1'b1;
                        od_next = {head.sem, head.thread};
                        n_next  = n_reg + 1'b1;
                        ol_next = !more_rel;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
endmodule

// ===== rtl/core/tdl_cell.sv =====
// One slot of the timer list; holds an entry's total wait and shifts with its neighbors.
// Depends on tdl_pkg.
module tdl_cell import tdl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  logic     first,
    input  logic     occ_left,
    input  entry_t   ent_left,
    input  entry_t   ent_right,
    input  logic     occ_right,
    input  chain_t   cin,
    output chain_t   cout,
    output entry_t   ent,
    output logic     occ
);
    entry_t ent_reg, ent_next;
    logic   occ_reg, occ_next;
    logic   here_ins, here_rem;

    // insert goes before this cell if this cell is free or its due exceeds t
    // (at the head: when t <= due)
    always_comb
    begin
        if (first)
            here_ins = !occ_reg || (op.timeout <= ent_reg.due);
        else
            here_ins = !occ_reg || (op.timeout < ent_reg.due);
    end
    assign here_rem = occ_reg && ent_reg.thread == op.thread && !cin.past_rem;

    always_comb
    begin
        cout.past_ins = cin.past_ins || here_ins;
        cout.past_rem = cin.past_rem || here_rem;
        ent_next = ent_reg;
        occ_next = occ_reg;
        if (op.ins)
        begin
            if (cin.past_ins)
            begin
                ent_next = ent_left;
                occ_next = occ_left;
            end
            else if (here_ins)
            begin
                ent_next.due    = op.timeout;
                ent_next.thread = op.thread;
                ent_next.sem    = op.sem;
                occ_next        = 1'b1;
            end
        end
        else if (op.rem)
        begin
            if (cin.past_rem || here_rem)
            begin
                ent_next = ent_right;
                occ_next = occ_right;
            end
        end
        else if (op.dec)
        begin
            if (occ_reg)
                ent_next.due = ent_reg.due - 16'd1;
        end
        else if (op.pop)
        begin
            ent_next = ent_right;
            occ_next = occ_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;
    assign occ = occ_reg;
endmodule

// ===== rtl/core/tdl_chain.sv =====
// Row of timer list cells, each linked to its left and right neighbor.
// Depends on tdl_pkg and tdl_cell.
module tdl_chain import tdl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    output entry_t   head,
    output logic     head_occ,
    output entry_t   second,
    output logic     second_occ,
    output logic     full
);
    entry_t ent [CAPACITY];
    logic   occ [CAPACITY];
    chain_t ch  [CAPACITY+1];
    entry_t left_ent [CAPACITY];
    entry_t right_ent [CAPACITY];
    logic   left_occ [CAPACITY];
    logic   right_occ [CAPACITY];

    assign ch[0] = '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_l0
                assign left_ent[i] = '0;
                assign left_occ[i] = 1'b0;
            end
            else
            begin : g_l
                assign left_ent[i] = ent[i-1];
                assign left_occ[i] = occ[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_rl
                assign right_ent[i] = '0;
                assign right_occ[i] = 1'b0;
            end
            else
            begin : g_r
                assign right_ent[i] = ent[i+1];
                assign right_occ[i] = occ[i+1];
            end
            tdl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .first     (i == 0),
                .occ_left  (left_occ[i]),
                .ent_left  (left_ent[i]),
                .ent_right (right_ent[i]),
                .occ_right (right_occ[i]),
                .cin       (ch[i]),
                .cout      (ch[i+1]),
                .ent       (ent[i]),
                .occ       (occ[i])
            );
        end
    endgenerate

    assign head       = ent[0];
    assign head_occ   = occ[0];
    assign second     = ent[1];
    assign second_occ = occ[1];
    assign full       = occ[CAPACITY-1];
endmodule
